/* rtl/p2cba_pkg.sv */
// Shared types, constants and helper functions for the power-of-two class block allocator.
package p2cba_pkg;

    localparam int unsigned ARENA_MAX_BYTES = 65536;
    localparam int unsigned HEADER_BYTES    = 16;
    localparam int unsigned MIN_BLOCK_BYTES = 8;
    localparam int unsigned NUM_CLASSES     = 16;
    localparam int unsigned STORE_DEPTH     = 8192;

    localparam int SIZE_W         = 17;
    localparam int ADDR_W         = 16;
    localparam int CLASS_W        = 5;
    localparam int HEAD_IDX_W     = $clog2(NUM_CLASSES);
    localparam int STORE_IDX_W    = $clog2(STORE_DEPTH);
    localparam int STORED_CLASS_W = HEAD_IDX_W;
    localparam int STATUS_W       = 3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_ARENA = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NULL_FREE    = 3'd4;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   granted_address;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   bytes_left;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic rd_en;
        logic wb_phase;
        logic commit;
        logic cfg_wr;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_read;
    } dp_stat_t;

    // Smallest c with 2^c >= v; zero for v of zero or one.
    function automatic logic [CLASS_W-1:0] ceil_log2(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0]  m;
        logic [CLASS_W-1:0] r;
        m = v - SIZE_W'(1);
        r = '0;
        if (v > SIZE_W'(1)) begin
            for (int i = 0; i < SIZE_W; i++) begin
                if (m[i]) begin
                    r = CLASS_W'(i + 1);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [STORE_IDX_W-1:0] store_idx(input logic [ADDR_W-1:0] a);
        return a[ADDR_W-1:ADDR_W-STORE_IDX_W];
    endfunction

endpackage

/* rtl/p2cba_ctrl.sv */
// Controller state machine that sequences one allocator transaction at a time.
module p2cba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  p2cba_pkg::dp_stat_t stat,
    output p2cba_pkg::ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WB
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // A configuration write takes precedence over a waiting transaction.
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

    always_comb begin
        cmd.load_in  = s_valid && s_ready;
        cmd.cfg_wr   = cfg_valid && (state_reg == ST_IDLE);
        cmd.wb_phase = (state_reg == ST_WB);
        cmd.rd_en    = (state_reg == ST_EXEC) && stat.needs_read;
        cmd.commit   = out_free && (((state_reg == ST_EXEC) && !stat.needs_read) ||
                                    (state_reg == ST_WB));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load_in) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.needs_read) begin
                    state_next = ST_WB;
                end else if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WB: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EXEC)
        else $error("accepted transaction did not enter execution");

    a_wb_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WB |-> $past(cmd.rd_en) || $past(state_reg) == ST_WB)
        else $error("write-back phase entered without a memory read");

    a_commit_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("committed result not presented or controller not idle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !cmd.commit)
        else $error("result register overwritten while still pending");
`endif

endmodule

/* rtl/p2cba_datapath.sv */
// Datapath of the allocator: list heads, bump pointer, link and class stores, result register.
module p2cba_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  p2cba_pkg::ctl_cmd_t             cmd,
    output p2cba_pkg::dp_stat_t             stat,
    input  p2cba_pkg::in_item_t             s_data,
    input  logic [p2cba_pkg::SIZE_W-1:0]    cfg_data,
    output p2cba_pkg::out_item_t            m_data
);

    p2cba_pkg::in_item_t  in_reg;
    p2cba_pkg::out_item_t out_reg;
    p2cba_pkg::out_item_t res;

    logic [p2cba_pkg::ADDR_W-1:0]  heads_reg [p2cba_pkg::NUM_CLASSES];
    logic [p2cba_pkg::SIZE_W-1:0]  bump_reg;
    logic [p2cba_pkg::SIZE_W-1:0]  remain_reg;
    logic [p2cba_pkg::CLASS_W-1:0] class_count_reg;

    logic [p2cba_pkg::ADDR_W-1:0]         link_mem  [p2cba_pkg::STORE_DEPTH];
    logic [p2cba_pkg::STORED_CLASS_W-1:0] class_mem [p2cba_pkg::STORE_DEPTH];
    logic [p2cba_pkg::ADDR_W-1:0]         link_rd_reg;
    logic [p2cba_pkg::STORED_CLASS_W-1:0] class_rd_reg;

    logic                                 is_alloc;
    logic [p2cba_pkg::CLASS_W-1:0]        req_class;
    logic                                 class_ok;
    logic                                 rd_class_ok;
    logic [p2cba_pkg::HEAD_IDX_W-1:0]     head_idx;
    logic [p2cba_pkg::ADDR_W-1:0]         head_val;
    logic [p2cba_pkg::SIZE_W-1:0]         pow_bytes;
    logic [p2cba_pkg::SIZE_W-1:0]         data_bytes;
    logic [p2cba_pkg::SIZE_W-1:0]         full_bytes;
    logic [p2cba_pkg::CLASS_W-1:0]        carved_class;
    logic                                 fits;
    logic [p2cba_pkg::ADDR_W-1:0]         new_addr;
    logic [p2cba_pkg::STORE_IDX_W-1:0]    rd_idx;
    logic [p2cba_pkg::SIZE_W-1:0]         eff_bytes;
    logic                                 do_bump;
    logic                                 do_pop;
    logic                                 do_push;

    assign is_alloc    = (in_reg.kind == p2cba_pkg::KIND_ALLOC);
    assign req_class   = p2cba_pkg::ceil_log2(in_reg.request_size);
    assign class_ok    = req_class < class_count_reg;
    assign rd_class_ok = {1'b0, class_rd_reg} < class_count_reg;

    // During the write-back of a free the list is chosen by the class read from the store.
    assign head_idx = (cmd.wb_phase && !is_alloc) ? class_rd_reg
                                                  : req_class[p2cba_pkg::HEAD_IDX_W-1:0];
    assign head_val = heads_reg[head_idx];

    assign pow_bytes    = p2cba_pkg::SIZE_W'(1) << req_class;
    assign data_bytes   = (pow_bytes < p2cba_pkg::SIZE_W'(p2cba_pkg::MIN_BLOCK_BYTES))
                          ? p2cba_pkg::SIZE_W'(p2cba_pkg::MIN_BLOCK_BYTES) : pow_bytes;
    assign full_bytes   = data_bytes + p2cba_pkg::SIZE_W'(p2cba_pkg::HEADER_BYTES);
    assign carved_class = p2cba_pkg::ceil_log2(data_bytes);
    assign fits         = remain_reg >= full_bytes;
    assign new_addr     = bump_reg[p2cba_pkg::ADDR_W-1:0] +
                          p2cba_pkg::ADDR_W'(p2cba_pkg::HEADER_BYTES);

    assign rd_idx = is_alloc ? p2cba_pkg::store_idx(head_val)
                             : p2cba_pkg::store_idx(in_reg.block_address);

    assign eff_bytes = (cfg_data > p2cba_pkg::SIZE_W'(p2cba_pkg::ARENA_MAX_BYTES))
                       ? p2cba_pkg::SIZE_W'(p2cba_pkg::ARENA_MAX_BYTES) : cfg_data;

    // A pop needs the link of the head block; a non-null free needs the block's class.
    always_comb begin
        if (is_alloc) begin
            stat.needs_read = (in_reg.request_size != '0) && class_ok && (head_val != '0);
        end else begin
            stat.needs_read = (in_reg.block_address != '0);
        end
    end

    always_comb begin
        res.granted_address = '0;
        res.status          = p2cba_pkg::STATUS_OK;
        res.bytes_left      = remain_reg;
        do_bump             = 1'b0;
        do_pop              = 1'b0;
        do_push             = 1'b0;
        if (cmd.wb_phase) begin
            if (is_alloc) begin
                do_pop              = 1'b1;
                res.granted_address = head_val;
            end else begin
                // A block whose class lies beyond the current list count is dropped.
                do_push = rd_class_ok;
            end
        end else if (is_alloc) begin
            if (in_reg.request_size == '0) begin
                res.status = p2cba_pkg::STATUS_ZERO_SIZE;
            end else if (!class_ok) begin
                res.status = p2cba_pkg::STATUS_TOO_LARGE;
            end else if (fits) begin
                do_bump             = 1'b1;
                res.granted_address = new_addr;
                res.bytes_left      = remain_reg - full_bytes;
            end else begin
                res.status = p2cba_pkg::STATUS_OUT_OF_ARENA;
            end
        end else begin
            res.status = p2cba_pkg::STATUS_NULL_FREE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < p2cba_pkg::NUM_CLASSES; i++) begin
                heads_reg[i] <= '0;
            end
            bump_reg        <= '0;
            remain_reg      <= p2cba_pkg::SIZE_W'(p2cba_pkg::ARENA_MAX_BYTES);
            class_count_reg <= p2cba_pkg::ceil_log2(
                                   p2cba_pkg::SIZE_W'(p2cba_pkg::ARENA_MAX_BYTES));
        end else if (cmd.cfg_wr) begin
            for (int i = 0; i < p2cba_pkg::NUM_CLASSES; i++) begin
                heads_reg[i] <= '0;
            end
            bump_reg        <= '0;
            remain_reg      <= eff_bytes;
            class_count_reg <= p2cba_pkg::ceil_log2(eff_bytes);
        end else if (cmd.commit) begin
            if (do_bump) begin
                bump_reg   <= bump_reg + full_bytes;
                remain_reg <= remain_reg - full_bytes;
            end
            if (do_pop) begin
                heads_reg[head_idx] <= link_rd_reg;
            end
            if (do_push) begin
                heads_reg[head_idx] <= in_reg.block_address;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.commit) begin
            out_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            link_rd_reg  <= link_mem[rd_idx];
            class_rd_reg <= class_mem[rd_idx];
        end
        if (cmd.commit && do_bump) begin
            class_mem[p2cba_pkg::store_idx(new_addr)] <=
                carved_class[p2cba_pkg::STORED_CLASS_W-1:0];
        end
        if (cmd.commit && do_push) begin
            link_mem[p2cba_pkg::store_idx(in_reg.block_address)] <= head_val;
        end
    end

    assign m_data = out_reg;

endmodule

/* rtl/pow2_class_block_allocator.sv */
// Top level of the power-of-two class block allocator.
// Each transaction either allocates a block (rounded up to a power-of-two class, taken from
// that class's free list or carved from the bump pointer with a 16-byte header) or frees a
// block onto the list of the class recorded when it was carved; one result returns per
// transaction with the granted user-data offset, a status code and the uncarved bytes left.
// One transaction is handled at a time. A zero-size, oversize, carve or null-free
// transaction goes from acceptance through the execute state to its registered result; a
// pop from a free list or a non-null free also passes through a write-back state, because
// the link and class stores are synchronous RAMs and their registered read data is needed
// before the list head is written back. The next transaction is accepted only once the
// controller is idle again. A pending result that is not taken stalls completion of the
// next one. A configuration write that is offered together with a transaction is taken
// first. Writing the arena size empties all lists at once (the list heads are flip-flops),
// so no clearing pass follows reset or a configuration write.
module pow2_class_block_allocator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  p2cba_pkg::in_item_t          s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output p2cba_pkg::out_item_t         m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [p2cba_pkg::SIZE_W-1:0] cfg_data
);

    p2cba_pkg::ctl_cmd_t cmd;
    p2cba_pkg::dp_stat_t stat;

    p2cba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    p2cba_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_data   (s_data),
        .cfg_data (cfg_data),
        .m_data   (m_data)
    );

endmodule
